/* sv/lab_pkg.sv */
// Shared types for the look-at basis block: vector and queue item structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lab_pkg;

    // Number of bits of a normalized magnitude before the square root.
    localparam int E_BITS = 30;

    // Steps of the bit-serial square root and of each quotient.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    // Unit magnitude in Q1.30.
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } vec32_t;

    typedef struct packed {
        logic signed [63:0] z;
        logic signed [63:0] y;
        logic signed [63:0] x;
    } vec64_t;

    // One classified item: the direction to normalize and the up hint.
    typedef struct packed {
        vec32_t dir;
        vec32_t up;
    } item_t;

endpackage

`default_nettype wire

/* sv/look_at_basis.sv */
// Top level of the look-at basis block: front, queue, three normalizers and
// two cross products, and the output register. Depends on lab_pkg, lab_front,
// lab_fifo, lab_cross and lab_norm.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  s       | in        | s_tvalid, s_tready | s_tdata: pos xyz, aim xyz, up xyz
//          |           |                    | s_tuser: func
//  m       | out       | m_tvalid, m_tready | m_tdata: fwd xyz, side xyz, new_up xyz
//          |           |                    | m_tuser: degenerate
//
// One item is taken every cycle while the output side keeps up; most of the
// pipeline lies in the three normalizers (32 square-root steps and 32
// quotient steps each).
// Reset clears only valid bits, queue pointers and count, and the output register flag.
// A stall on m holds the whole back pipeline; the queue then fills, and the
// front keeps s_tready high until both the queue and its own register are full.
`default_nettype none

module look_at_basis #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [287:0]   s_tdata,   // pos_x, pos_y, pos_z, aim_x, aim_y,
                                           // aim_z, up_x, up_y, up_z
    input  wire logic           s_tuser,   // func
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [287:0]        m_tdata,   // fwd_x, fwd_y, fwd_z, side_x, side_y,
                                           // side_z, new_up_x, new_up_y, new_up_z
    output logic                m_tuser    // degenerate
);
    import lab_pkg::*;

    // Front and queue.
    logic           fr_valid;
    item_t          fr_item;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    item_t          q_item;

    // The back pipeline moves as one whenever the output register can take
    // a transfer.
    logic           adv;

    logic           n1_valid;
    vec32_t         n1_vec;
    logic           n1_zero;
    logic [95:0]    n1_side;
    vec64_t         dir64;

    logic           c1_valid;
    vec64_t         c1_vec;
    logic [96:0]    c1_side;

    logic           n2_valid;
    vec32_t         n2_vec;
    logic           n2_zero;
    logic [96:0]    n2_side;
    vec32_t         n2_fwd;

    logic           c2_valid;
    vec64_t         c2_vec;
    logic [192:0]   c2_side;

    logic           n3_valid;
    vec32_t         n3_vec;
    logic           n3_zero;
    logic [192:0]   n3_side;
    vec32_t         n3_fwd;
    vec32_t         n3_sd;
    logic           deg_c;

    logic           m_valid_reg;
    logic           m_valid_next;
    logic [287:0]   m_data_reg;
    logic           m_deg_reg;

    assign adv   = !m_valid_reg || m_tready;
    assign q_pop = adv && !q_empty;

    lab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_valid (fr_valid),
        .out_item  (fr_item),
        .out_ready (!q_full)
    );

    lab_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_valid && !q_full),
        .push_item (fr_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    assign dir64.x = 64'(q_item.dir.x);
    assign dir64.y = 64'(q_item.dir.y);
    assign dir64.z = 64'(q_item.dir.z);

    // Forward: the normalized direction; the up hint rides along.
    lab_norm #(
        .SW (96)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (!q_empty),
        .in_vec    (dir64),
        .in_side   (q_item.up),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    lab_cross #(
        .SW (97)
    ) u_cross_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (n1_valid),
        .a         (n1_vec),
        .b         (vec32_t'(n1_side)),
        .in_side   ({n1_vec, n1_zero}),
        .out_valid (c1_valid),
        .c         (c1_vec),
        .out_side  (c1_side)
    );

    // Side: forward cross up, normalized.
    lab_norm #(
        .SW (97)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c1_valid),
        .in_vec    (c1_vec),
        .in_side   (c1_side),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    assign n2_fwd = vec32_t'(n2_side[96:1]);

    lab_cross #(
        .SW (193)
    ) u_cross_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (n2_valid),
        .a         (n2_vec),
        .b         (n2_fwd),
        .in_side   ({n2_fwd, n2_vec, n2_side[0] | n2_zero}),
        .out_valid (c2_valid),
        .c         (c2_vec),
        .out_side  (c2_side)
    );

    // New up: side cross forward, normalized.
    lab_norm #(
        .SW (193)
    ) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c2_valid),
        .in_vec    (c2_vec),
        .in_side   (c2_side),
        .out_valid (n3_valid),
        .out_vec   (n3_vec),
        .out_zero  (n3_zero),
        .out_side  (n3_side)
    );

    assign n3_fwd = vec32_t'(n3_side[192:97]);
    assign n3_sd  = vec32_t'(n3_side[96:1]);
    assign deg_c  = n3_side[0] | n3_zero;

    assign m_valid_next = adv ? n3_valid : m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    // Any zero length along the way zeroes the whole basis.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_deg_reg <= deg_c;
            if (deg_c)
                m_data_reg <= '0;
            else
                m_data_reg <= {n3_vec.z, n3_vec.y, n3_vec.x,
                               n3_sd.z, n3_sd.y, n3_sd.x,
                               n3_fwd.z, n3_fwd.y, n3_fwd.x};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_deg_reg;

`ifndef ASSERT_OFF
    a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result carries nonzero components");

    a_fwd_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824)
                  && ($signed(m_tdata[31:0]) >= -32'sd1073741824))
        else $error("forward x outside the unit range");

    a_fwd_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[95:0] != '0)
        else $error("valid basis with a zero forward vector");
`endif

endmodule

`default_nettype wire

/* sv/lab_front.sv */
// Front part of the look-at basis block: takes input transfers, forms the
// direction (aim, or target minus eye, saturated) and holds it for the queue.
// Depends on lab_pkg.
`default_nettype none

module lab_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [287:0]   s_tdata,
    input  wire logic           s_tuser,
    output logic                out_valid,
    output lab_pkg::item_t      out_item,
    input  wire logic           out_ready
);
    import lab_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    item_t         item_reg;
    item_t         item_next;
    logic signed [31:0] pos [3];
    logic signed [31:0] aim [3];
    logic signed [31:0] dir [3];
    logic signed [32:0] diff [3];

    assign s_tready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos[i]  = s_tdata[32*i +: 32];
            aim[i]  = s_tdata[96 + 32*i +: 32];
            diff[i] = 33'(aim[i]) - 33'(pos[i]);
            if (!s_tuser)
                dir[i] = aim[i];
            else if (diff[i][32] != diff[i][31])
                dir[i] = diff[i][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                dir[i] = diff[i][31:0];
        end
        item_next.dir.x = dir[0];
        item_next.dir.y = dir[1];
        item_next.dir.z = dir[2];
        item_next.up.x  = s_tdata[192 +: 32];
        item_next.up.y  = s_tdata[224 +: 32];
        item_next.up.z  = s_tdata[256 +: 32];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

/* sv/lab_fifo.sv */
// Short queue between the front and back parts of the look-at basis block.
// Depends on lab_pkg for the item type.
`default_nettype none

module lab_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lab_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output lab_pkg::item_t      pop_item,
    output logic                empty
);
    import lab_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    item_t          mem [DEPTH];
    logic [AW-1:0]  wr_reg;
    logic [AW-1:0]  wr_next;
    logic [AW-1:0]  rd_reg;
    logic [AW-1:0]  rd_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_item;
    end

endmodule

`default_nettype wire

/* sv/lab_cross.sv */
// Two-stage pipelined cross product a x b of 32-bit vectors into 64 bits.
// Depends on lab_pkg for the vector types.
`default_nettype none

module lab_cross #(
    parameter int SW = 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire lab_pkg::vec32_t a,
    input  wire lab_pkg::vec32_t b,
    input  wire logic [SW-1:0]  in_side,
    output logic                out_valid,
    output lab_pkg::vec64_t     c,
    output logic [SW-1:0]       out_side
);
    import lab_pkg::*;

    logic               p_valid_reg;
    logic [SW-1:0]      p_side_reg;
    logic signed [63:0] p_reg [6];
    logic signed [63:0] p_next [6];
    logic               c_valid_reg;
    logic [SW-1:0]      c_side_reg;
    vec64_t             c_reg;

    always_comb
    begin
        p_next[0] = a.y * b.z;
        p_next[1] = a.z * b.y;
        p_next[2] = a.z * b.x;
        p_next[3] = a.x * b.z;
        p_next[4] = a.x * b.y;
        p_next[5] = a.y * b.x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
            c_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
                p_reg[i] <= p_next[i];
            p_side_reg <= in_side;
            c_reg.x    <= p_reg[0] - p_reg[1];
            c_reg.y    <= p_reg[2] - p_reg[3];
            c_reg.z    <= p_reg[4] - p_reg[5];
            c_side_reg <= p_side_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign c         = c_reg;
    assign out_side  = c_side_reg;

endmodule

`default_nettype wire

/* sv/lab_norm.sv */
// Pipelined normalizer: scales a 64-bit vector to 30-bit magnitudes, takes a
// bit-serial square root and three restoring quotients, one step per stage.
// Depends on lab_pkg for vector types and step counts.
`default_nettype none

module lab_norm #(
    parameter int SW = 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire lab_pkg::vec64_t in_vec,
    input  wire logic [SW-1:0]  in_side,
    output logic                out_valid,
    output lab_pkg::vec32_t     out_vec,
    output logic                out_zero,
    output logic [SW-1:0]       out_side
);
    import lab_pkg::*;

    // Front stages: magnitudes, leading-one search in two steps, scaling, squares.
    logic signed [63:0] vin [3];
    logic [63:0]        mag_c [3];
    logic               s0_valid, s1_valid, s2_valid, s3_valid, s4_valid;
    logic [SW-1:0]      s0_side, s1_side, s2_side, s3_side, s4_side;
    logic [2:0]         s0_neg, s1_neg, s2_neg, s3_neg, s4_neg;
    logic [63:0]        s0_mag [3];
    logic [63:0]        s1_mag [3];
    logic [63:0]        s2_mag [3];
    logic [63:0]        s0_or;
    logic               s1_zero, s2_zero, s3_zero, s4_zero;
    logic [2:0]         s1_grp;
    logic [7:0]         s1_byte;
    logic [2:0]         grp_c;
    logic [2:0]         pos_c;
    logic [6:0]         s2_bl;
    logic [6:0]         rsh_c;
    logic [6:0]         lsh_c;
    logic [63:0]        sh_c [3];
    logic [E_BITS-1:0]  s3_e [3];
    logic [E_BITS-1:0]  s4_e [3];
    logic [2*E_BITS-1:0] s4_sq [3];
    logic [61:0]        sum_c;

    // Square root stages.
    logic               q_valid [SQRT_STEPS+1];
    logic [SW-1:0]      q_side  [SQRT_STEPS+1];
    logic [2:0]         q_neg   [SQRT_STEPS+1];
    logic               q_zero  [SQRT_STEPS+1];
    logic [E_BITS-1:0]  q_e     [SQRT_STEPS+1][3];
    logic [63:0]        q_n     [SQRT_STEPS+1];
    logic [63:0]        q_r     [SQRT_STEPS+1];

    // Quotient stages.
    logic               d_valid [DIV_STEPS+1];
    logic [SW-1:0]      d_side  [DIV_STEPS+1];
    logic [2:0]         d_neg   [DIV_STEPS+1];
    logic               d_zero  [DIV_STEPS+1];
    logic [31:0]        d_rt    [DIV_STEPS+1];
    logic [32:0]        d_rem   [DIV_STEPS+1][3];
    logic [31:0]        d_q     [DIV_STEPS+1][3];

    logic               o_valid_reg;
    logic               o_zero_reg;
    logic [SW-1:0]      o_side_reg;
    vec32_t             o_vec_reg;
    logic [31:0]        qc_c [3];
    logic [31:0]        res_c [3];

    assign vin[0] = in_vec.x;
    assign vin[1] = in_vec.y;
    assign vin[2] = in_vec.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag_c[i] = vin[i][63] ? (~vin[i] + 64'd1) : vin[i];
    end

    always_comb
    begin
        grp_c = '0;
        for (int g = 0; g < 8; g++)
            if (s0_or[8*g +: 8] != 8'd0)
                grp_c = 3'(g);
        pos_c = '0;
        for (int b = 0; b < 8; b++)
            if (s1_byte[b])
                pos_c = 3'(b);
    end

    always_comb
    begin
        rsh_c = s2_bl - 7'd30;
        lsh_c = 7'd30 - s2_bl;
        for (int i = 0; i < 3; i++)
            sh_c[i] = (s2_bl > 7'd30) ? (s2_mag[i] >> rsh_c) : (s2_mag[i] << lsh_c);
        sum_c = 62'(s4_sq[0]) + 62'(s4_sq[1]) + 62'(s4_sq[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid   <= 1'b0;
            s1_valid   <= 1'b0;
            s2_valid   <= 1'b0;
            s3_valid   <= 1'b0;
            s4_valid   <= 1'b0;
            q_valid[0] <= 1'b0;
        end
        else if (en)
        begin
            s0_valid   <= in_valid;
            s1_valid   <= s0_valid;
            s2_valid   <= s1_valid;
            s3_valid   <= s2_valid;
            s4_valid   <= s3_valid;
            q_valid[0] <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_side <= in_side;
            for (int i = 0; i < 3; i++)
            begin
                s0_neg[i] <= vin[i][63];
                s0_mag[i] <= mag_c[i];
            end
            s0_or   <= mag_c[0] | mag_c[1] | mag_c[2];

            s1_side <= s0_side;
            s1_neg  <= s0_neg;
            s1_mag  <= s0_mag;
            s1_zero <= (s0_or == 64'd0);
            s1_grp  <= grp_c;
            s1_byte <= s0_or[8*grp_c +: 8];

            s2_side <= s1_side;
            s2_neg  <= s1_neg;
            s2_mag  <= s1_mag;
            s2_zero <= s1_zero;
            s2_bl   <= {1'b0, s1_grp, pos_c} + 7'd1;

            s3_side <= s2_side;
            s3_neg  <= s2_neg;
            s3_zero <= s2_zero;
            for (int i = 0; i < 3; i++)
                s3_e[i] <= sh_c[i][E_BITS-1:0];

            s4_side <= s3_side;
            s4_neg  <= s3_neg;
            s4_zero <= s3_zero;
            for (int i = 0; i < 3; i++)
            begin
                s4_e[i]  <= s3_e[i];
                s4_sq[i] <= s3_e[i] * s3_e[i];
            end

            q_side[0] <= s4_side;
            q_neg[0]  <= s4_neg;
            q_zero[0] <= s4_zero;
            for (int i = 0; i < 3; i++)
                q_e[0][i] <= s4_e[i];
            q_n[0]    <= {sum_c, 2'b00};
            q_r[0]    <= '0;
        end
    end

    // One root bit per stage; the trial bit walks down from bit 62.
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
        logic [63:0] t_c;

        assign t_c = q_r[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q_valid[k+1] <= 1'b0;
            else if (en)
                q_valid[k+1] <= q_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_side[k+1] <= q_side[k];
                q_neg[k+1]  <= q_neg[k];
                q_zero[k+1] <= q_zero[k];
                for (int i = 0; i < 3; i++)
                    q_e[k+1][i] <= q_e[k][i];
                if (q_n[k] >= t_c)
                begin
                    q_n[k+1] <= q_n[k] - t_c;
                    q_r[k+1] <= (q_r[k] >> 1) + BIT;
                end
                else
                begin
                    q_n[k+1] <= q_n[k];
                    q_r[k+1] <= q_r[k] >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid[0] <= 1'b0;
        else if (en)
            d_valid[0] <= q_valid[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side[0] <= q_side[SQRT_STEPS];
            d_neg[0]  <= q_neg[SQRT_STEPS];
            d_zero[0] <= q_zero[SQRT_STEPS];
            d_rt[0]   <= q_r[SQRT_STEPS][31:0];
            for (int i = 0; i < 3; i++)
            begin
                d_rem[0][i] <= 33'(q_e[SQRT_STEPS][i]);
                d_q[0][i]   <= '0;
            end
        end
    end

    // Quotient (e * 2^32 + R) / (2 R): the low word of the dividend is R,
    // fed in one bit per stage from the top.
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [33:0] dv_c;
        logic [33:0] t_c [3];

        assign dv_c = {1'b0, d_rt[j], 1'b0};

        always_comb
        begin
            for (int i = 0; i < 3; i++)
                t_c[i] = {d_rem[j][i], d_rt[j][31-j]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_valid[j+1] <= 1'b0;
            else if (en)
                d_valid[j+1] <= d_valid[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_side[j+1] <= d_side[j];
                d_neg[j+1]  <= d_neg[j];
                d_zero[j+1] <= d_zero[j];
                d_rt[j+1]   <= d_rt[j];
                for (int i = 0; i < 3; i++)
                begin
                    if (t_c[i] >= dv_c)
                    begin
                        d_rem[j+1][i] <= 33'(t_c[i] - dv_c);
                        d_q[j+1][i]   <= {d_q[j][i][30:0], 1'b1};
                    end
                    else
                    begin
                        d_rem[j+1][i] <= t_c[i][32:0];
                        d_q[j+1][i]   <= {d_q[j][i][30:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qc_c[i]  = (d_q[DIV_STEPS][i] > Q30_ONE) ? Q30_ONE : d_q[DIV_STEPS][i];
            if (d_zero[DIV_STEPS])
                res_c[i] = '0;
            else if (d_neg[DIV_STEPS][i])
                res_c[i] = ~qc_c[i] + 32'd1;
            else
                res_c[i] = qc_c[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= d_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_side_reg  <= d_side[DIV_STEPS];
            o_zero_reg  <= d_zero[DIV_STEPS];
            o_vec_reg.x <= res_c[0];
            o_vec_reg.y <= res_c[1];
            o_vec_reg.z <= res_c[2];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_zero  = o_zero_reg;
    assign out_side  = o_side_reg;

endmodule

`default_nettype wire
